// ===== hdl/aasmr_pkg.sv =====
`timescale 1ns / 1ps
package aasmr_pkg;

    localparam int CANDIDATE_SLOTS_DEF = 64;
    localparam int SLOT_W = 6;
    localparam int COORD_W = 32;
    // Sums of a center and a local box offset need one extra bit.
    localparam int WIDE_W = COORD_W + 1;

    localparam logic [1:0] FUNC_WRITE = 2'd0;
    localparam logic [1:0] FUNC_CLEAR = 2'd1;
    localparam logic [1:0] FUNC_LOCAL = 2'd2;
    localparam logic [1:0] FUNC_MOVE  = 2'd3;

    typedef struct packed {
        logic [1:0]                func;
        logic [SLOT_W-1:0]         slot;
        logic [31:0]               ident;
        logic                      terrain_flag;
        logic signed [COORD_W-1:0] a_x;
        logic signed [COORD_W-1:0] a_y;
        logic signed [COORD_W-1:0] a_z;
        logic signed [COORD_W-1:0] b_x;
        logic signed [COORD_W-1:0] b_y;
        logic signed [COORD_W-1:0] b_z;
        logic signed [COORD_W-1:0] body_height;
    } cmd_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] center_x;
        logic signed [COORD_W-1:0] center_y;
        logic signed [COORD_W-1:0] center_z;
        logic                      collided_x;
        logic                      collided_z;
    } result_t;

    // Query box broadcast down the chain of cells.
    typedef struct packed {
        logic signed [WIDE_W-1:0] lo_x;
        logic signed [WIDE_W-1:0] lo_y;
        logic signed [WIDE_W-1:0] lo_z;
        logic signed [WIDE_W-1:0] hi_x;
        logic signed [WIDE_W-1:0] hi_y;
        logic signed [WIDE_W-1:0] hi_z;
        logic [31:0]              ident;
    } query_t;

    // Write or clear request seen by every cell.
    typedef struct packed {
        logic                      wr;
        logic                      clr;
        logic [31:0]               ident;
        logic                      terrain;
        logic signed [COORD_W-1:0] min_x;
        logic signed [COORD_W-1:0] min_y;
        logic signed [COORD_W-1:0] min_z;
        logic signed [COORD_W-1:0] max_x;
        logic signed [COORD_W-1:0] max_y;
        logic signed [COORD_W-1:0] max_z;
    } cell_wr_t;

    function automatic logic signed [COORD_W-1:0] sat32(input logic signed [WIDE_W-1:0] v);
        logic signed [COORD_W-1:0] r;
        if (v[WIDE_W-1] != v[WIDE_W-2])
        begin
            r = v[WIDE_W-1] ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
        end
        else
        begin
            r = v[COORD_W-1:0];
        end
        return r;
    endfunction

endpackage

// ===== hdl/aasmr_cell.sv =====
`timescale 1ns / 1ps
module aasmr_cell (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              sel,
    input  aasmr_pkg::cell_wr_t wr,
    input  aasmr_pkg::query_t query,
    input  logic              hit_in,
    output logic              hit_out
);
    logic                              valid_reg;
    logic [31:0]                       ident_reg;
    logic                              terrain_reg;
    logic signed [aasmr_pkg::COORD_W-1:0] min_x_reg, min_y_reg, min_z_reg;
    logic signed [aasmr_pkg::COORD_W-1:0] max_x_reg, max_y_reg, max_z_reg;
    logic                              hit_reg;
    logic                              hit_next;
    logic                              mine;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (wr.clr)
        begin
            valid_reg <= 1'b0;
        end
        else if (wr.wr && sel)
        begin
            valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.wr && sel)
        begin
            ident_reg   <= wr.ident;
            terrain_reg <= wr.terrain;
            min_x_reg   <= wr.min_x;
            min_y_reg   <= wr.min_y;
            min_z_reg   <= wr.min_z;
            max_x_reg   <= wr.max_x;
            max_y_reg   <= wr.max_y;
            max_z_reg   <= wr.max_z;
        end
    end

    // Inclusive overlap on all three axes; the query is one bit wider.
    always_comb
    begin
        mine = valid_reg && !terrain_reg && (ident_reg != query.ident)
            && !(query.lo_x > $signed({max_x_reg[31], max_x_reg}))
            && !(query.hi_x < $signed({min_x_reg[31], min_x_reg}))
            && !(query.lo_y > $signed({max_y_reg[31], max_y_reg}))
            && !(query.hi_y < $signed({min_y_reg[31], min_y_reg}))
            && !(query.lo_z > $signed({max_z_reg[31], max_z_reg}))
            && !(query.hi_z < $signed({min_z_reg[31], min_z_reg}));
        hit_next = mine || hit_in;
    end

    // Registered local match; the OR chain to the neighbor is a single gate.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg <= 1'b0;
        end
        else
        begin
            hit_reg <= mine;
        end
    end

    assign hit_out = hit_reg | hit_in;

    // hit_next names the combinational view used for the assertion below.
    a_or_chain: assert property (@(posedge clk) disable iff (!rst_n)
        hit_in |-> hit_out)
        else $error("hit lost along the chain");
    a_match: assert property (@(posedge clk) disable iff (!rst_n)
        mine |=> hit_out)
        else $error("match not registered");
    a_next: assert property (@(posedge clk) disable iff (!rst_n)
        hit_next == (mine || hit_in))
        else $error("hit_next mismatch");
endmodule

// ===== hdl/aabb_axis_separated_move_resolver.sv =====
`timescale 1ns / 1ps
// Write, clear and local box items are registered when accepted; a move steps through
// x query, x hit, z query, z hit and result strobe. Throughput: one item per cycle
// for table writes while not busy; busy holds off any new item until a move is done;
// the x then z query through the row of compare cells sets the move time.
// Reset clears all candidate valid bits and the mover box; results cannot be stalled.
module aabb_axis_separated_move_resolver #(
    parameter int CANDIDATE_SLOTS = aasmr_pkg::CANDIDATE_SLOTS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  aasmr_pkg::cmd_t    cmd,
    output logic               busy,
    output logic               strobe,
    output aasmr_pkg::result_t result
);
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_XQ   = 3'd1;
    localparam logic [2:0] ST_XH   = 3'd2;
    localparam logic [2:0] ST_ZQ   = 3'd3;
    localparam logic [2:0] ST_ZH   = 3'd4;

    localparam int CW = aasmr_pkg::COORD_W;
    localparam int WW = aasmr_pkg::WIDE_W;

    logic [2:0]  state_reg, state_next;
    aasmr_pkg::cmd_t mv_reg;
    logic signed [CW-1:0] cx_reg, cz_reg, tx_reg, tz_reg;
    logic hx_reg, hz_reg;
    logic signed [CW-1:0] box_reg [6];
    logic strobe_reg;
    aasmr_pkg::result_t res_reg;

    aasmr_pkg::cell_wr_t wr;
    aasmr_pkg::query_t   query;
    logic [CANDIDATE_SLOTS:0] chain;
    logic accept;
    logic signed [CW-1:0] qx, qz, half;

    assign accept = start && !busy;
    assign busy = (state_reg != ST_IDLE);

    always_comb
    begin
        wr.wr      = accept && (cmd.func == aasmr_pkg::FUNC_WRITE)
                     && ({26'd0, cmd.slot} < 32'(CANDIDATE_SLOTS));
        wr.clr     = accept && (cmd.func == aasmr_pkg::FUNC_CLEAR);
        wr.ident   = cmd.ident;
        wr.terrain = cmd.terrain_flag;
        wr.min_x   = cmd.a_x;
        wr.min_y   = cmd.a_y;
        wr.min_z   = cmd.a_z;
        wr.max_x   = cmd.b_x;
        wr.max_y   = cmd.b_y;
        wr.max_z   = cmd.b_z;
    end

    // Query center: x pass uses the trial x, z pass the resolved x and trial z.
    always_comb
    begin
        qx = (state_reg == ST_XQ || state_reg == ST_XH) ? tx_reg : cx_reg;
        qz = (state_reg == ST_XQ || state_reg == ST_XH) ? cz_reg : tz_reg;
        query.lo_x  = WW'(qx) + WW'(box_reg[0]);
        query.lo_y  = WW'(mv_reg.a_y) + WW'(box_reg[1]);
        query.lo_z  = WW'(qz) + WW'(box_reg[2]);
        query.hi_x  = WW'(qx) + WW'(box_reg[3]);
        query.hi_y  = WW'(mv_reg.a_y) + WW'(box_reg[4]);
        query.hi_z  = WW'(qz) + WW'(box_reg[5]);
        query.ident = mv_reg.ident;
    end

    assign chain[0] = 1'b0;
    for (genvar g = 0; g < CANDIDATE_SLOTS; g++)
    begin : g_cell
        aasmr_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .sel     (32'(cmd.slot) == g),
            .wr      (wr),
            .query   (query),
            .hit_in  (chain[g]),
            .hit_out (chain[g+1])
        );
    end

    assign half = mv_reg.body_height >>> 1;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (accept && cmd.func == aasmr_pkg::FUNC_MOVE) state_next = ST_XQ;
            ST_XQ:   state_next = ST_XH;
            ST_XH:   state_next = ST_ZQ;
            ST_ZQ:   state_next = ST_ZH;
            ST_ZH:   state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            strobe_reg <= 1'b0;
            for (int i = 0; i < 6; i++)
            begin
                box_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg  <= state_next;
            strobe_reg <= (state_reg == ST_ZH);
            if (accept && cmd.func == aasmr_pkg::FUNC_LOCAL)
            begin
                box_reg[0] <= cmd.a_x;
                box_reg[1] <= cmd.a_y;
                box_reg[2] <= cmd.a_z;
                box_reg[3] <= cmd.b_x;
                box_reg[4] <= cmd.b_y;
                box_reg[5] <= cmd.b_z;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && cmd.func == aasmr_pkg::FUNC_MOVE)
        begin
            mv_reg <= cmd;
            cx_reg <= cmd.a_x;
            cz_reg <= cmd.a_z;
            tx_reg <= aasmr_pkg::sat32(WW'(cmd.a_x) + WW'(cmd.b_x));
            hx_reg <= 1'b0;
            hz_reg <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                ST_XH:
                begin
                    if (mv_reg.b_x != '0)
                    begin
                        if (chain[CANDIDATE_SLOTS]) hx_reg <= 1'b1;
                        else cx_reg <= tx_reg;
                    end
                    tz_reg <= aasmr_pkg::sat32(WW'(cz_reg) + WW'(mv_reg.b_z));
                end
                ST_ZH:
                begin
                    res_reg.center_x <= cx_reg;
                    res_reg.collided_x <= hx_reg;
                    if (mv_reg.b_z != '0 && chain[CANDIDATE_SLOTS])
                    begin
                        res_reg.center_z   <= cz_reg;
                        res_reg.collided_z <= 1'b1;
                    end
                    else
                    begin
                        res_reg.center_z   <= (mv_reg.b_z != '0) ? tz_reg : cz_reg;
                        res_reg.collided_z <= 1'b0;
                    end
                    if (mv_reg.b_x != '0 || mv_reg.b_z != '0)
                    begin
                        res_reg.center_y <= aasmr_pkg::sat32(WW'(mv_reg.b_y) + WW'(half));
                    end
                    else
                    begin
                        res_reg.center_y <= mv_reg.a_y;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    assign strobe = strobe_reg;
    assign result = res_reg;

    a_strobe_after_move: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> $past(state_reg) == ST_ZH)
        else $error("strobe without a finished move");
    a_busy_move: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && cmd.func == aasmr_pkg::FUNC_MOVE) |=> busy)
        else $error("move did not hold busy");
    a_no_motion: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && mv_reg.b_x == '0 && mv_reg.b_z == '0)
        |-> (!result.collided_x && !result.collided_z))
        else $error("flag set without motion");
endmodule

// ===== sim/aabb_axis_separated_move_resolver_tb.sv =====
`timescale 1ns / 1ps
module aabb_axis_separated_move_resolver_tb;

    localparam int SLOTS = aasmr_pkg::CANDIDATE_SLOTS_DEF;
    localparam int COORD_W = aasmr_pkg::COORD_W;
    localparam int SLOT_W = aasmr_pkg::SLOT_W;
    localparam int RANDOM_ITEMS = 2000;
    localparam int IDLE_LIMIT = 5000;
    localparam int DRAIN_CYCLES = 20;

    typedef struct packed {
        logic                      valid;
        logic [31:0]               ident;
        logic                      terrain;
        logic signed [COORD_W-1:0] min_x;
        logic signed [COORD_W-1:0] min_y;
        logic signed [COORD_W-1:0] min_z;
        logic signed [COORD_W-1:0] max_x;
        logic signed [COORD_W-1:0] max_y;
        logic signed [COORD_W-1:0] max_z;
    } box_entry_t;

    typedef struct {
        aasmr_pkg::cmd_t    cmd;
        logic               has_result;
        logic               known;
        aasmr_pkg::result_t want;
    } row_t;

    logic               clk;
    logic               rst_n;
    logic               start;
    aasmr_pkg::cmd_t    cmd;
    logic               busy;
    logic               strobe;
    aasmr_pkg::result_t result;

    box_entry_t table_m [SLOTS];
    logic signed [COORD_W-1:0] local_lo [3];
    logic signed [COORD_W-1:0] local_hi [3];
    aasmr_pkg::result_t pending_moves [$];
    aasmr_pkg::result_t typed_moves [$];
    logic    typed_flags [$];
    int      failures;
    int      idle_cycles;
    bit      accepted;

    aabb_axis_separated_move_resolver dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .cmd    (cmd),
        .busy   (busy),
        .strobe (strobe),
        .result (result)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    function automatic logic signed [COORD_W-1:0] clamp_sum(longint a, longint b);
        longint s;
        s = a + b;
        if (s > 64'sd2147483647)
        begin
            return 32'sh7fffffff;
        end
        if (s < -64'sd2147483648)
        begin
            return 32'sh80000000;
        end
        return s[31:0];
    endfunction

    function automatic bit mover_blocked(logic [31:0] id, logic signed [COORD_W-1:0] cx,
                                         logic signed [COORD_W-1:0] cy,
                                         logic signed [COORD_W-1:0] cz);
        longint lo [3];
        longint hi [3];
        longint cmin [3];
        longint cmax [3];
        bit hit;
        lo[0] = longint'(cx) + local_lo[0];
        lo[1] = longint'(cy) + local_lo[1];
        lo[2] = longint'(cz) + local_lo[2];
        hi[0] = longint'(cx) + local_hi[0];
        hi[1] = longint'(cy) + local_hi[1];
        hi[2] = longint'(cz) + local_hi[2];
        for (int s = 0; s < SLOTS; s++)
        begin
            if (table_m[s].valid && !table_m[s].terrain && table_m[s].ident != id)
            begin
                cmin[0] = table_m[s].min_x;
                cmin[1] = table_m[s].min_y;
                cmin[2] = table_m[s].min_z;
                cmax[0] = table_m[s].max_x;
                cmax[1] = table_m[s].max_y;
                cmax[2] = table_m[s].max_z;
                hit = 1'b1;
                for (int k = 0; k < 3; k++)
                begin
                    if (lo[k] > cmax[k] || hi[k] < cmin[k])
                    begin
                        hit = 1'b0;
                    end
                end
                if (hit)
                begin
                    return 1'b1;
                end
            end
        end
        return 1'b0;
    endfunction

    // Applies one item to the predictor; returns 1 when a move result is expected.
    function automatic bit resolve_item(aasmr_pkg::cmd_t c, output aasmr_pkg::result_t r);
        logic signed [COORD_W-1:0] nx;
        logic signed [COORD_W-1:0] nz;
        r = '0;
        case (c.func)
            aasmr_pkg::FUNC_WRITE:
            begin
                table_m[c.slot] = '{1'b1, c.ident, c.terrain_flag, c.a_x, c.a_y, c.a_z,
                                    c.b_x, c.b_y, c.b_z};
                return 1'b0;
            end
            aasmr_pkg::FUNC_CLEAR:
            begin
                for (int s = 0; s < SLOTS; s++)
                begin
                    table_m[s].valid = 1'b0;
                end
                return 1'b0;
            end
            aasmr_pkg::FUNC_LOCAL:
            begin
                local_lo[0] = c.a_x;
                local_lo[1] = c.a_y;
                local_lo[2] = c.a_z;
                local_hi[0] = c.b_x;
                local_hi[1] = c.b_y;
                local_hi[2] = c.b_z;
                return 1'b0;
            end
            default:
            begin
                r.center_x = c.a_x;
                r.center_y = c.a_y;
                r.center_z = c.a_z;
                if (c.b_x != 0 || c.b_z != 0)
                begin
                    if (c.b_x != 0)
                    begin
                        nx = clamp_sum(c.a_x, c.b_x);
                        if (mover_blocked(c.ident, nx, r.center_y, r.center_z))
                        begin
                            r.collided_x = 1'b1;
                        end
                        else
                        begin
                            r.center_x = nx;
                        end
                    end
                    if (c.b_z != 0)
                    begin
                        nz = clamp_sum(c.a_z, c.b_z);
                        if (mover_blocked(c.ident, r.center_x, r.center_y, nz))
                        begin
                            r.collided_z = 1'b1;
                        end
                        else
                        begin
                            r.center_z = nz;
                        end
                    end
                    r.center_y = clamp_sum(c.b_y, c.body_height >>> 1);
                end
                return 1'b1;
            end
        endcase
    endfunction

    function automatic aasmr_pkg::cmd_t make_cmd(logic [1:0] f, int sl, logic [31:0] id,
                                                 logic terr, int ax, int ay, int az,
                                                 int bx, int by, int bz, int h);
        aasmr_pkg::cmd_t c;
        c = '{f, sl[SLOT_W-1:0], id, terr, ax, ay, az, bx, by, bz, h};
        return c;
    endfunction

    function automatic logic signed [31:0] rand_coord();
        case ($urandom_range(0, 9))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            2: return 0;
            3, 4, 5: return $urandom;
            default: return $signed($urandom_range(0, 16'hffff) << 8) - 32'sd8388608;
        endcase
    endfunction

    function automatic logic signed [31:0] rand_velocity();
        case ($urandom_range(0, 7))
            0: return 0;
            1: return $urandom;
            default: return $signed($urandom_range(0, 32'h80000)) - 32'sh40000;
        endcase
    endfunction

    function automatic aasmr_pkg::cmd_t random_cmd();
        aasmr_pkg::cmd_t c;
        int sel;
        int lo;
        c = '0;
        c.ident = $urandom_range(0, 7);
        if ($urandom_range(0, 9) == 0)
        begin
            c.ident = $urandom;
        end
        sel = $urandom_range(0, 99);
        if (sel < 35)
        begin
            c.func = aasmr_pkg::FUNC_WRITE;
            c.slot = SLOT_W'($urandom);
            c.terrain_flag = $urandom_range(0, 3) == 0;
            c.a_x = rand_coord();
            c.a_y = rand_coord();
            c.a_z = rand_coord();
            lo = $urandom_range(0, 9) == 0 ? -int'($urandom_range(1, 100000))
                                           : int'($urandom_range(0, 32'h400000));
            c.b_x = $urandom_range(0, 9) == 0 ? rand_coord() : clamp_sum(c.a_x, lo);
            c.b_y = $urandom_range(0, 9) == 0 ? rand_coord() : 32'sh7fffffff;
            c.b_z = $urandom_range(0, 9) == 0 ? rand_coord()
                                              : clamp_sum(c.a_z, $urandom_range(0, 32'h400000));
            if ($urandom_range(0, 4) == 0)
            begin
                c.a_y = 32'sh80000000;
            end
        end
        else if (sel < 37)
        begin
            c.func = aasmr_pkg::FUNC_CLEAR;
            c.slot = SLOT_W'($urandom);
            c.a_x = $urandom;
            c.b_z = $urandom;
        end
        else if (sel < 42)
        begin
            c.func = aasmr_pkg::FUNC_LOCAL;
            c.a_x = -int'($urandom_range(0, 32'h20000));
            c.a_y = -int'($urandom_range(0, 32'h20000));
            c.a_z = -int'($urandom_range(0, 32'h20000));
            c.b_x = $urandom_range(0, 32'h20000);
            c.b_y = $urandom_range(0, 32'h20000);
            c.b_z = $urandom_range(0, 32'h20000);
            if ($urandom_range(0, 5) == 0)
            begin
                c.a_x = rand_coord();
                c.b_z = rand_coord();
            end
        end
        else
        begin
            c.func = aasmr_pkg::FUNC_MOVE;
            c.slot = SLOT_W'($urandom);
            c.terrain_flag = 1'($urandom);
            c.a_x = rand_coord();
            c.a_y = $urandom;
            c.a_z = rand_coord();
            c.b_x = rand_velocity();
            c.b_y = $urandom;
            c.b_z = rand_velocity();
            c.body_height = $urandom;
        end
        return c;
    endfunction

    // Drives one item and holds it until the block takes it.
    task automatic send_item(aasmr_pkg::cmd_t c);
        aasmr_pkg::result_t r;
        cmd <= c;
        start <= 1'b1;
        @(posedge clk);
        while (busy)
        begin
            @(posedge clk);
        end
        if (resolve_item(c, r))
        begin
            pending_moves.push_back(r);
        end
    endtask

    task automatic idle_gap();
        int n;
        n = $urandom_range(0, 3) == 0 ? $urandom_range(1, 8) : 0;
        if (n > 0)
        begin
            start <= 1'b0;
            cmd <= random_cmd();
            repeat (n) @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        while (pending_moves.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        aasmr_pkg::result_t want;
        accepted = 1'b0;
        if (rst_n && start && !busy)
        begin
            accepted = 1'b1;
        end
        if (rst_n && strobe)
        begin
            accepted = 1'b1;
            if (pending_moves.size() == 0)
            begin
                $error("result with no move waiting");
                failures++;
            end
            else
            begin
                want = pending_moves.pop_front();
                if (typed_moves.size() != 0 && typed_flags[0])
                begin
                    if (typed_moves[0] != want)
                    begin
                        $error("predictor disagrees with typed row: expected %h actual %h",
                               typed_moves[0], want);
                        failures++;
                    end
                end
                if (typed_moves.size() != 0)
                begin
                    void'(typed_moves.pop_front());
                    void'(typed_flags.pop_front());
                end
                if (result.center_x !== want.center_x)
                begin
                    $error("center_x expected %h actual %h", want.center_x, result.center_x);
                    failures++;
                end
                if (result.center_y !== want.center_y)
                begin
                    $error("center_y expected %h actual %h", want.center_y, result.center_y);
                    failures++;
                end
                if (result.center_z !== want.center_z)
                begin
                    $error("center_z expected %h actual %h", want.center_z, result.center_z);
                    failures++;
                end
                if (result.collided_x !== want.collided_x)
                begin
                    $error("collided_x expected %b actual %b", want.collided_x,
                           result.collided_x);
                    failures++;
                end
                if (result.collided_z !== want.collided_z)
                begin
                    $error("collided_z expected %b actual %b", want.collided_z,
                           result.collided_z);
                    failures++;
                end
            end
        end
        idle_cycles = accepted ? 0 : idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("aabb_axis_separated_move_resolver test failed");
            $finish;
        end
    end

    localparam int MAXP = 32'h7fffffff;
    localparam int MINN = 32'h80000000;
    localparam int ONE = 32'h10000;

    row_t rows [$];

    task automatic add_row(aasmr_pkg::cmd_t c, logic known, aasmr_pkg::result_t w);
        row_t r;
        r.cmd = c;
        r.has_result = c.func == aasmr_pkg::FUNC_MOVE;
        r.known = known;
        r.want = w;
        rows.push_back(r);
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        cmd = '0;
        failures = 0;
        idle_cycles = 0;
        for (int s = 0; s < SLOTS; s++)
        begin
            table_m[s] = '0;
        end
        for (int k = 0; k < 3; k++)
        begin
            local_lo[k] = 0;
            local_hi[k] = 0;
        end

        // No motion straight after reset: center comes back untouched.
        add_row(make_cmd(aasmr_pkg::FUNC_MOVE, 0, 1, 0, 5, 6, 7, 0, 100, 0, 8), 1'b1,
                '{5, 6, 7, 1'b0, 1'b0});
        // Empty table: free move with y snapped, and saturation at the extremes.
        add_row(make_cmd(aasmr_pkg::FUNC_MOVE, 63, 32'hffffffff, 1, MAXP, 0, MINN, MAXP,
                         MAXP, MINN, MAXP), 1'b1, '{MAXP, MAXP, MINN, 1'b0, 1'b0});
        // Odd negative height rounds toward minus infinity.
        add_row(make_cmd(aasmr_pkg::FUNC_MOVE, 0, 2, 0, 0, 0, 0, ONE, MINN, 0, -3), 1'b1,
                '{ONE, MINN, 0, 1'b0, 1'b0});
        add_row(make_cmd(aasmr_pkg::FUNC_MOVE, 0, 2, 0, 0, 0, 0, 0, 10, -ONE, -3), 1'b1,
                '{0, 8, -ONE, 1'b0, 1'b0});
        add_row(make_cmd(aasmr_pkg::FUNC_LOCAL, 0, 0, 0, -ONE, -ONE, -ONE, ONE, ONE, ONE, 0),
                1'b0, '0);
        // Wall at x in [4,5], touching on edge counts as a hit.
        add_row(make_cmd(aasmr_pkg::FUNC_WRITE, 0, 9, 0, 4*ONE, -10*ONE, -10*ONE, 5*ONE,
                         10*ONE, 10*ONE, 0), 1'b0, '0);
        add_row(make_cmd(aasmr_pkg::FUNC_MOVE, 0, 1, 0, 0, 0, 0, 3*ONE, 0, ONE, 2*ONE), 1'b1,
                '{0, ONE, ONE, 1'b1, 1'b0});
        add_row(make_cmd(aasmr_pkg::FUNC_MOVE, 0, 1, 0, 0, 0, 0, 3*ONE - 1, 0, 0, 0), 1'b1,
                '{3*ONE - 1, 0, 0, 1'b0, 1'b0});
        // Same id as the candidate: no hit.
        add_row(make_cmd(aasmr_pkg::FUNC_MOVE, 0, 9, 0, 0, 0, 0, 3*ONE, 0, 0, 0), 1'b1,
                '{3*ONE, 0, 0, 1'b0, 1'b0});
        // Terrain candidate in z is skipped, then a solid one blocks z.
        add_row(make_cmd(aasmr_pkg::FUNC_WRITE, 1, 5, 1, -10*ONE, -10*ONE, 4*ONE, 10*ONE,
                         10*ONE, 5*ONE, 0), 1'b0, '0);
        add_row(make_cmd(aasmr_pkg::FUNC_MOVE, 0, 1, 0, 0, 0, 0, 0, 0, 3*ONE, 0), 1'b1,
                '{0, 0, 3*ONE, 1'b0, 1'b0});
        add_row(make_cmd(aasmr_pkg::FUNC_WRITE, 1, 5, 0, -10*ONE, -10*ONE, 4*ONE, 10*ONE,
                         10*ONE, 5*ONE, 0), 1'b0, '0);
        add_row(make_cmd(aasmr_pkg::FUNC_MOVE, 0, 1, 0, 0, 0, 0, 3*ONE, 0, 3*ONE, 0), 1'b1,
                '{0, 0, 0, 1'b1, 1'b1});
        // Inverted box is never hit; extreme slot and extreme field values.
        add_row(make_cmd(aasmr_pkg::FUNC_WRITE, 63, 32'hffffffff, 0, MAXP, MAXP, MAXP, MINN,
                         MINN, MINN, MAXP), 1'b0, '0);
        add_row(make_cmd(aasmr_pkg::FUNC_WRITE, 62, 0, 0, MINN, MINN, MINN, MAXP, MAXP, MAXP,
                         MINN), 1'b0, '0);
        add_row(make_cmd(aasmr_pkg::FUNC_MOVE, 0, 3, 0, MINN, MINN, MINN, MINN, MAXP, MAXP,
                         MINN), 1'b0, '0);
        add_row(make_cmd(aasmr_pkg::FUNC_LOCAL, 0, 0, 0, MINN, MINN, MINN, MAXP, MAXP, MAXP,
                         0), 1'b0, '0);
        add_row(make_cmd(aasmr_pkg::FUNC_MOVE, 0, 0, 0, MAXP, MAXP, MAXP, MAXP, 0, -1, MAXP),
                1'b0, '0);
        // Clear empties the table: the wall no longer blocks.
        add_row(make_cmd(aasmr_pkg::FUNC_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, '0);
        add_row(make_cmd(aasmr_pkg::FUNC_LOCAL, 0, 0, 0, -ONE, -ONE, -ONE, ONE, ONE, ONE, 0),
                1'b0, '0);
        add_row(make_cmd(aasmr_pkg::FUNC_MOVE, 0, 1, 0, 0, 0, 0, 3*ONE, 0, 3*ONE, 0), 1'b1,
                '{3*ONE, 0, 3*ONE, 1'b0, 1'b0});

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[i])
        begin
            if (rows[i].has_result)
            begin
                typed_moves.push_back(rows[i].want);
                typed_flags.push_back(rows[i].known);
            end
            send_item(rows[i].cmd);
            if ($urandom_range(0, 2) == 0)
            begin
                idle_gap();
            end
        end
        wait_drained();
        typed_moves.delete();
        typed_flags.delete();

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            send_item(random_cmd());
            if (n % 150 == 0)
            begin
                idle_gap();
            end
            else if ($urandom_range(0, 40) == 0)
            begin
                // Burst ends here: a gap of random length.
                start <= 1'b0;
                cmd <= random_cmd();
                repeat ($urandom_range(1, 20)) @(posedge clk);
            end
            if (n == RANDOM_ITEMS / 2)
            begin
                wait_drained();
            end
        end
        wait_drained();

        if (failures == 0)
        begin
            $display("aabb_axis_separated_move_resolver test passed");
        end
        else
        begin
            $display("aabb_axis_separated_move_resolver test failed");
        end
        $finish;
    end
endmodule
